// ===== hdl/rau_pkg.sv =====
// shared types and constants for the rational arithmetic unit
`default_nettype none
package rau_pkg;
   localparam int WORD_WIDTH = 32;
   localparam int MAG_WIDTH = 64;
   localparam int CNT_WIDTH = $clog2(MAG_WIDTH + 1);

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_GT  = 3'd4,
      CMD_EQ  = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_GCD_CHECK,
      ST_GCD_DIV,
      ST_RED_N,
      ST_RED_D,
      ST_DONE
   } state_type;

   // divider operand selects
   typedef enum logic [1:0] {
      DSEL_X_BY_Y,
      DSEL_Y_BY_X,
      DSEL_N_BY_G,
      DSEL_D_BY_G
   } dsel_type;

   typedef struct packed {
      logic     load;
      logic     mul1;
      logic     mul2;
      logic     sum;
      logic     div_start;
      dsel_type div_sel;
      logic     div_store;
      logic     finish;
   } ctrl_type;

   typedef struct packed {
      logic arith;
      logic x_zero;
      logic y_zero;
      logic x_gt_y;
      logic div_done;
   } stat_type;
endpackage
`default_nettype wire

// ===== hdl/rational_arithmetic_unit_core.sv =====
// top level of the rational arithmetic unit
// compares and unused commands step through mul1, mul2 and done before the registered strobe
// arithmetic adds sum, gcd check, the euclid steps and the reduction of both terms; a zero gcd
// goes from gcd check straight to done; euclid and reduction use the shared bit-serial 64-bit divider
// one word at a time: busy stays high until the result strobe
// synchronous reset returns the controller to idle with no strobe pending
`default_nettype none
module rational_arithmetic_unit_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_command,
   input  wire logic signed [31:0] req_a_numerator,
   input  wire logic signed [31:0] req_a_denominator,
   input  wire logic signed [31:0] req_b_numerator,
   input  wire logic signed [31:0] req_b_denominator,
   output logic                    rsp_strobe,
   output logic signed [63:0]      rsp_result_numerator,
   output logic signed [63:0]      rsp_result_denominator,
   output logic                    rsp_compare_true,
   output logic                    rsp_error
);
   rau_pkg::ctrl_type ctrl;
   rau_pkg::stat_type stat;

   // sequencer: owns handshake and step order
   rau_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .strobe(rsp_strobe), .ctrl(ctrl), .stat(stat)
   );

   // datapath: products, gcd and the result word
   rau_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_command(req_command),
      .req_a_numerator(req_a_numerator), .req_a_denominator(req_a_denominator),
      .req_b_numerator(req_b_numerator), .req_b_denominator(req_b_denominator),
      .rsp_result_numerator(rsp_result_numerator),
      .rsp_result_denominator(rsp_result_denominator),
      .rsp_compare_true(rsp_compare_true), .rsp_error(rsp_error)
   );
endmodule
`default_nettype wire

// ===== hdl/rau_divider.sv =====
// restoring 64-bit unsigned divider, one quotient bit per cycle
`default_nettype none
module rau_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rau_pkg::MAG_WIDTH-1:0] dividend,
   input  wire logic [rau_pkg::MAG_WIDTH-1:0] divisor,
   output logic                             done,
   output logic [rau_pkg::MAG_WIDTH-1:0]    quotient,
   output logic [rau_pkg::MAG_WIDTH-1:0]    remainder
);
   localparam int W = rau_pkg::MAG_WIDTH;
   logic [W-1:0] q_ff, q_in, d_ff, d_in;
   logic [W:0]   r_ff, r_in, trial;
   logic [rau_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      trial = {r_ff[W-1:0], q_ff[W-1]} - {1'b0, d_ff};
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = dividend; d_in = divisor; r_in = '0;
         cnt_in = rau_pkg::CNT_WIDTH'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[W]) begin
            r_in = {r_ff[W-1:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end else begin
            r_in = trial;
            q_in = {q_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rau_pkg::CNT_WIDTH'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff[W-1:0];
endmodule
`default_nettype wire

// ===== hdl/rau_datapath.sv =====
// operand registers, product unit, gcd registers and result formatting
`default_nettype none
module rau_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rau_pkg::ctrl_type               ctrl,
   output rau_pkg::stat_type                    stat,
   input  wire logic [2:0]                      req_command,
   input  wire logic signed [31:0]              req_a_numerator,
   input  wire logic signed [31:0]              req_a_denominator,
   input  wire logic signed [31:0]              req_b_numerator,
   input  wire logic signed [31:0]              req_b_denominator,
   output logic signed [63:0]                   rsp_result_numerator,
   output logic signed [63:0]                   rsp_result_denominator,
   output logic                                 rsp_compare_true,
   output logic                                 rsp_error
);
   localparam int WW = rau_pkg::WORD_WIDTH;
   localparam int MW = rau_pkg::MAG_WIDTH;
   localparam logic [MW-1:0] TOP = {1'b1, {(MW-1){1'b0}}};

   logic [2:0] cmd_ff;
   logic signed [WW-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [MW-1:0] p1_ff, p2_ff, p3_ff;
   logic [MW-1:0] x_ff, y_ff, n_ff, d_ff;
   logic nneg_ff, dneg_ff;
   logic [MW-1:0] nraw, draw, nmag, dmag;
   logic signed [WW-1:0] m1a, m1b, m2a, m2b;
   logic signed [MW-1:0] prod_a, prod_b;
   logic [MW-1:0] dv_n, dv_d, quo, rem;
   logic dv_done;
   logic cmp_ff, cmp_in, err_ff, err_in;
   logic [MW-1:0] rn_ff, rd_ff, rn_in, rd_in;

   rau_divider u_div (
      .clock(clock), .reset(reset), .start(ctrl.div_start),
      .dividend(dv_n), .divisor(dv_d),
      .done(dv_done), .quotient(quo), .remainder(rem)
   );

   // two 32x32 products in the mul1 phase and one in mul2, operands chosen per phase
   always_comb begin
      if (ctrl.mul1) begin
         m1a = an_ff; m1b = bd_ff;
         m2a = (rau_pkg::cmd_type'(cmd_ff) == rau_pkg::CMD_MUL) ? an_ff : bn_ff;
         m2b = (rau_pkg::cmd_type'(cmd_ff) == rau_pkg::CMD_MUL) ? bn_ff : ad_ff;
      end else begin
         m1a = ad_ff;
         m1b = (rau_pkg::cmd_type'(cmd_ff) == rau_pkg::CMD_DIV) ? bn_ff : bd_ff;
         m2a = '0; m2b = '0;
      end
      prod_a = MW'(m1a) * MW'(m1b);
      prod_b = MW'(m2a) * MW'(m2b);
   end

   always_comb begin
      unique case (rau_pkg::cmd_type'(cmd_ff))
         rau_pkg::CMD_ADD: nraw = p1_ff + p2_ff;
         rau_pkg::CMD_SUB: nraw = p1_ff - p2_ff;
         rau_pkg::CMD_MUL: nraw = p2_ff;
         default:          nraw = p1_ff;
      endcase
      draw = p3_ff;
      nmag = (nraw[MW-1] && nraw != TOP) ? -nraw : nraw;
      dmag = (draw[MW-1] && draw != TOP) ? -draw : draw;
   end

   always_comb begin
      unique case (ctrl.div_sel)
         rau_pkg::DSEL_X_BY_Y: begin dv_n = x_ff; dv_d = y_ff; end
         rau_pkg::DSEL_Y_BY_X: begin dv_n = y_ff; dv_d = x_ff; end
         rau_pkg::DSEL_N_BY_G: begin dv_n = n_ff; dv_d = x_ff | y_ff; end
         default:              begin dv_n = d_ff; dv_d = x_ff | y_ff; end
      endcase
   end

   always_comb begin
      cmp_in = cmp_ff; err_in = err_ff; rn_in = rn_ff; rd_in = rd_ff;
      if (ctrl.finish) begin
         cmp_in = 1'b0; err_in = 1'b0; rn_in = '0; rd_in = MW'(1);
         unique case (cmd_ff)
            3'(rau_pkg::CMD_GT): cmp_in = p1_ff > p2_ff;
            3'(rau_pkg::CMD_EQ): cmp_in = (an_ff == bn_ff) && (ad_ff == bd_ff);
            3'(rau_pkg::CMD_ADD), 3'(rau_pkg::CMD_SUB),
            3'(rau_pkg::CMD_MUL), 3'(rau_pkg::CMD_DIV): begin
               if ((x_ff | y_ff) == '0) err_in = 1'b1;
               else begin
                  rn_in = nneg_ff ? -n_ff : n_ff;
                  rd_in = dneg_ff ? -d_ff : d_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_command;
         an_ff <= req_a_numerator[WW-1:0]; ad_ff <= req_a_denominator[WW-1:0];
         bn_ff <= req_b_numerator[WW-1:0]; bd_ff <= req_b_denominator[WW-1:0];
      end
      if (ctrl.mul1) begin p1_ff <= prod_a; p2_ff <= prod_b; end
      if (ctrl.mul2) p3_ff <= prod_a;
      if (ctrl.sum) begin
         x_ff <= nmag; y_ff <= dmag; n_ff <= nmag; d_ff <= dmag;
         nneg_ff <= (nraw[MW-1] && nraw != TOP);
         dneg_ff <= (draw[MW-1] && draw != TOP);
      end
      if (ctrl.div_store) begin
         unique case (ctrl.div_sel)
            rau_pkg::DSEL_X_BY_Y: x_ff <= rem;
            rau_pkg::DSEL_Y_BY_X: y_ff <= rem;
            rau_pkg::DSEL_N_BY_G: n_ff <= quo;
            default:              d_ff <= quo;
         endcase
      end
      rn_ff <= rn_in; rd_ff <= rd_in; cmp_ff <= cmp_in; err_ff <= err_in;
   end

   assign stat.arith = ~cmd_ff[2];
   assign stat.x_zero = (x_ff == '0);
   assign stat.y_zero = (y_ff == '0);
   assign stat.x_gt_y = (x_ff > y_ff);
   assign stat.div_done = dv_done;
   assign rsp_result_numerator = rn_ff;
   assign rsp_result_denominator = rd_ff;
   assign rsp_compare_true = cmp_ff;
   assign rsp_error = err_ff;
endmodule
`default_nettype wire

// ===== hdl/rau_controller.sv =====
// sequencer for products, euclidean gcd and reduction
`default_nettype none
module rau_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   strobe,
   output rau_pkg::ctrl_type      ctrl,
   input  wire rau_pkg::stat_type stat
);
   rau_pkg::state_type state_ff, state_in;
   logic strobe_ff, strobe_in;
   logic sel_ff, sel_in;   // which side the running gcd step reduces; in ST_RED_D, set once the divider is started

   always_comb begin
      state_in = state_ff; strobe_in = 1'b0; sel_in = sel_ff;
      ctrl = '0;
      ctrl.div_sel = sel_ff ? rau_pkg::DSEL_Y_BY_X : rau_pkg::DSEL_X_BY_Y;
      unique case (state_ff)
         rau_pkg::ST_IDLE: if (start) begin
            ctrl.load = 1'b1; state_in = rau_pkg::ST_MUL1;
         end
         rau_pkg::ST_MUL1: begin ctrl.mul1 = 1'b1; state_in = rau_pkg::ST_MUL2; end
         rau_pkg::ST_MUL2: begin
            ctrl.mul2 = 1'b1;
            state_in = stat.arith ? rau_pkg::ST_SUM : rau_pkg::ST_DONE;
         end
         rau_pkg::ST_SUM: begin ctrl.sum = 1'b1; state_in = rau_pkg::ST_GCD_CHECK; end
         rau_pkg::ST_GCD_CHECK: begin
            if (stat.x_zero && stat.y_zero) state_in = rau_pkg::ST_DONE;
            else if (stat.x_zero || stat.y_zero) begin
               ctrl.div_start = 1'b1; ctrl.div_sel = rau_pkg::DSEL_N_BY_G;
               state_in = rau_pkg::ST_RED_N;
            end else begin
               sel_in = ~stat.x_gt_y;
               ctrl.div_start = 1'b1;
               ctrl.div_sel = stat.x_gt_y ? rau_pkg::DSEL_X_BY_Y : rau_pkg::DSEL_Y_BY_X;
               state_in = rau_pkg::ST_GCD_DIV;
            end
         end
         rau_pkg::ST_GCD_DIV: if (stat.div_done) begin
            ctrl.div_store = 1'b1; state_in = rau_pkg::ST_GCD_CHECK;
         end
         rau_pkg::ST_RED_N: begin
            ctrl.div_sel = rau_pkg::DSEL_N_BY_G;
            if (stat.div_done) begin
               ctrl.div_store = 1'b1;
               state_in = rau_pkg::ST_RED_D;
            end
         end
         rau_pkg::ST_RED_D: begin
            ctrl.div_sel = rau_pkg::DSEL_D_BY_G;
            if (stat.div_done) begin
               ctrl.div_store = 1'b1; state_in = rau_pkg::ST_DONE;
            end else if (!sel_ff) begin
               ctrl.div_start = 1'b1; sel_in = 1'b1;
            end
         end
         rau_pkg::ST_DONE: begin
            ctrl.finish = 1'b1; strobe_in = 1'b1; state_in = rau_pkg::ST_IDLE;
         end
         default: state_in = rau_pkg::ST_IDLE;
      endcase
      if (state_ff == rau_pkg::ST_RED_N && stat.div_done) sel_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      if (reset) begin
         state_ff <= rau_pkg::ST_IDLE; strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in; strobe_ff <= strobe_in;
      end
   end

   assign busy = (state_ff != rau_pkg::ST_IDLE);
   assign strobe = strobe_ff;

`ifndef ASSERT_OFF
   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> state_ff == rau_pkg::ST_IDLE) else $error("load outside idle");
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff) == rau_pkg::ST_DONE) else $error("stray strobe");
   a_idle_after_strobe: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> state_ff == rau_pkg::ST_IDLE) else $error("strobe not idle");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tb_rational_arithmetic_unit_core.sv =====
// self-checking testbench for the rational arithmetic unit core
`default_nettype none
module tb_rational_arithmetic_unit_core;
   timeunit 1ns;
   timeprecision 1ps;

   // command codes that the package leaves unnamed
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   localparam int RANDOM_WORDS = 1030;
   localparam int CALM_WORDS   = 150;      // tail of the run with no idling
   localparam int STALL_LIMIT  = 60000;
   localparam int TAIL_CYCLES  = 20;

   localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

   typedef struct {
      logic [2:0]         command;
      logic signed [31:0] an, ad, bn, bd;
      bit                 drain;   // hold this word until all results are back
   } word_type;

   typedef struct {
      logic signed [63:0] numerator, denominator;
      logic               compare_true, error;
   } quotient_type;

   logic clock, reset, start, busy;
   logic [2:0]         req_command;
   logic signed [31:0] req_a_numerator, req_a_denominator;
   logic signed [31:0] req_b_numerator, req_b_denominator;
   logic               rsp_strobe;
   logic signed [63:0] rsp_result_numerator, rsp_result_denominator;
   logic               rsp_compare_true, rsp_error;

   rational_arithmetic_unit_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command),
      .req_a_numerator(req_a_numerator), .req_a_denominator(req_a_denominator),
      .req_b_numerator(req_b_numerator), .req_b_denominator(req_b_denominator),
      .rsp_strobe(rsp_strobe),
      .rsp_result_numerator(rsp_result_numerator),
      .rsp_result_denominator(rsp_result_denominator),
      .rsp_compare_true(rsp_compare_true), .rsp_error(rsp_error)
   );

   word_type     word_q[$];       // words waiting for the driver
   quotient_type quotient_q[$];   // predicted results in order of acceptance
   int mismatches = 0;
   int checked = 0;
   int errors_seen = 0;
   int true_compares = 0;
   int cmd_count[8];
   int stall_cycles = 0;
   bit calm = 0;                  // no idle bursts once set
   bit offered = 0;
   bit took = 0;
   bit stim_done = 0;
   int gap_left = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // euclid on magnitudes, signs carried separately
   function automatic quotient_type predict_quotient(logic [2:0] cmd,
         logic signed [31:0] an, logic signed [31:0] ad,
         logic signed [31:0] bn, logic signed [31:0] bd);
      quotient_type r;
      logic signed [63:0] xan, xad, xbn, xbd, p_ab, p_ba;
      logic [64:0] nraw, draw;
      logic [63:0] nmag, dmag, x, y, g;
      r.numerator = 64'sd1 - 64'sd1;
      r.denominator = 64'sd1;
      r.compare_true = 1'b0;
      r.error = 1'b0;
      xan = an; xad = ad; xbn = bn; xbd = bd;
      p_ab = xan * xbd;
      p_ba = xbn * xad;
      // 65-bit intermediates so a sum reaching 2^63 stays exact
      case (cmd)
         rau_pkg::CMD_ADD: begin
            nraw = {p_ab[63], p_ab} + {p_ba[63], p_ba};
            draw = {1'b0, xad * xbd}; draw[64] = draw[63];
         end
         rau_pkg::CMD_SUB: begin
            nraw = {p_ab[63], p_ab} - {p_ba[63], p_ba};
            draw = {1'b0, xad * xbd}; draw[64] = draw[63];
         end
         rau_pkg::CMD_MUL: begin
            nraw = {1'b0, xan * xbn}; nraw[64] = nraw[63];
            draw = {1'b0, xad * xbd}; draw[64] = draw[63];
         end
         rau_pkg::CMD_DIV: begin
            nraw = {p_ab[63], p_ab};
            draw = {1'b0, xad * xbn}; draw[64] = draw[63];
         end
         rau_pkg::CMD_GT: begin
            r.compare_true = (p_ab > p_ba);
            return r;
         end
         rau_pkg::CMD_EQ: begin
            r.compare_true = (an == bn) && (ad == bd);
            return r;
         end
         default: return r;
      endcase
      nmag = nraw[64] ? 64'(-nraw) : nraw[63:0];
      dmag = draw[64] ? 64'(-draw) : draw[63:0];
      x = nmag;
      y = dmag;
      while (x != 0 && y != 0) begin
         if (x > y) x = x % y;
         else y = y % x;
      end
      g = x + y;
      if (g == 0) begin
         r.error = 1'b1;
         return r;
      end
      r.numerator = nraw[64] ? -$signed(nmag / g) : $signed(nmag / g);
      r.denominator = draw[64] ? -$signed(dmag / g) : $signed(dmag / g);
      return r;
   endfunction

   function automatic logic signed [31:0] pick_operand();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: case ($urandom_range(0, 4))
               0: return 32'sd0;
               1: return 32'sd1;
               2: return -32'sd1;
               3: return MOST_NEG;
               default: return MOST_POS;
            endcase
         1, 2, 3, 4, 5: return $signed(32'($urandom_range(0, 40))) - 32'sd20;
         // keep full-width operands less common, they make euclid slow
         6, 7: return $signed(32'($urandom_range(0, 4000))) - 32'sd2000;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic queue_word(logic [2:0] cmd, logic signed [31:0] an,
         logic signed [31:0] ad, logic signed [31:0] bn,
         logic signed [31:0] bd, bit drain);
      word_type w;
      w.command = cmd; w.an = an; w.ad = ad; w.bn = bn; w.bd = bd;
      w.drain = drain;
      word_q.push_back(w);
   endtask

   // stimulus: directed corners first, then random words
   initial begin
      logic [2:0] cmd;
      logic signed [31:0] an, ad, bn, bd;
      reset = 1'b1;
      start = 1'b0;
      req_command = rau_pkg::CMD_ADD;
      req_a_numerator = '0; req_a_denominator = '0;
      req_b_numerator = '0; req_b_denominator = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extreme operands; with every operand most negative the sum reaches 2^63
      queue_word(rau_pkg::CMD_ADD, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, 0);
      queue_word(rau_pkg::CMD_SUB, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS, 0);
      queue_word(rau_pkg::CMD_MUL, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, 0);
      queue_word(rau_pkg::CMD_DIV, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, 0);
      // zero gcd: both terms zero
      queue_word(rau_pkg::CMD_MUL, 32'sd0, 32'sd0, 32'sd5, 32'sd3, 0);
      queue_word(rau_pkg::CMD_ADD, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 0);
      // one term zero in the first three words
      queue_word(rau_pkg::CMD_MUL, 32'sd0, 32'sd7, 32'sd3, -32'sd9, 0);
      queue_word(rau_pkg::CMD_DIV, 32'sd4, 32'sd3, 32'sd0, 32'sd5, 0);
      queue_word(rau_pkg::CMD_SUB, 32'sd3, 32'sd4, 32'sd3, 32'sd4, 0);
      queue_word(rau_pkg::CMD_ADD, -32'sd1, 32'sd2, 32'sd1, -32'sd3, 0);
      queue_word(rau_pkg::CMD_GT, 32'sd1, 32'sd2, 32'sd1, 32'sd3, 0);
      queue_word(rau_pkg::CMD_GT, 32'sd1, -32'sd2, 32'sd1, 32'sd3, 0);
      queue_word(rau_pkg::CMD_GT, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, 0);
      queue_word(rau_pkg::CMD_GT, 32'sd2, 32'sd4, 32'sd1, 32'sd2, 0);
      queue_word(rau_pkg::CMD_EQ, 32'sd1, 32'sd2, 32'sd1, 32'sd2, 0);
      // equal in value but not raw
      queue_word(rau_pkg::CMD_EQ, 32'sd1, 32'sd2, 32'sd2, 32'sd4, 0);
      queue_word(rau_pkg::CMD_EQ, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, 0);
      queue_word(CMD_SPARE6, 32'sd3, 32'sd5, 32'sd7, 32'sd9, 0);
      queue_word(CMD_SPARE7, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
         an = pick_operand(); ad = pick_operand();
         bn = pick_operand(); bd = pick_operand();
         if (cmd == rau_pkg::CMD_EQ && $urandom_range(0, 1)) begin
            bn = an; bd = ad;
         end
         queue_word(cmd, an, ad, bn, bd, (i % 200) == 199);
         // let the driver empty the queue before the calm tail
         if (i == RANDOM_WORDS - CALM_WORDS) begin
            wait (word_q.size() == 0);
            calm = 1;
         end
      end
      wait (word_q.size() == 0 && !offered);
      stim_done = 1;
   end

   // driver: words change on the falling edge
   always @(negedge clock) begin
      word_type w;
      if (!reset) begin
         if (offered && took) begin
            void'(word_q.pop_front());
            offered = 0;
         end
         if (!offered) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (word_q.size() > 0 &&
                         !(word_q[0].drain && quotient_q.size() != 0)) begin
               w = word_q[0];
               req_command <= w.command;
               req_a_numerator <= w.an;
               req_a_denominator <= w.ad;
               req_b_numerator <= w.bn;
               req_b_denominator <= w.bd;
               offered = 1;
               if (!calm && $urandom_range(0, 3) == 0)
                  gap_left = $urandom_range(1, 16);
            end
         end
         start <= offered;
      end
   end

   // monitor: accept words and check results on the rising edge
   always @(posedge clock) begin
      quotient_type want;
      bit accepted;
      accepted = start && !busy && !reset;
      took <= accepted;
      if (accepted) begin
         quotient_q.push_back(predict_quotient(req_command, req_a_numerator,
            req_a_denominator, req_b_numerator, req_b_denominator));
         cmd_count[req_command]++;
      end
      if (!reset && rsp_strobe) begin
         if (quotient_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %0d/%0d cmp %0b err %0b",
                  rsp_result_numerator, rsp_result_denominator,
                  rsp_compare_true, rsp_error);
         end else begin
            want = quotient_q.pop_front();
            checked++;
            errors_seen += want.error;
            true_compares += want.compare_true;
            if (rsp_result_numerator !== want.numerator ||
                rsp_result_denominator !== want.denominator ||
                rsp_compare_true !== want.compare_true ||
                rsp_error !== want.error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at result %0d: expected %0d/%0d cmp %0b err %0b, got %0d/%0d cmp %0b err %0b",
                     checked, want.numerator, want.denominator,
                     want.compare_true, want.error, rsp_result_numerator,
                     rsp_result_denominator, rsp_compare_true, rsp_error);
            end
         end
      end
      // watchdog on cycles with no traffic
      if (accepted || rsp_strobe || reset) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d results outstanding",
            quotient_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      wait (quotient_q.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("checked %0d results: add %0d sub %0d mul %0d div %0d gt %0d eq %0d spare %0d",
         checked, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3],
         cmd_count[4], cmd_count[5], cmd_count[6] + cmd_count[7]);
      $display("zero gcd cases %0d, true compares %0d, mismatches %0d",
         errors_seen, true_compares, mismatches);
      if (mismatches == 0 && quotient_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
